// ----- rtl/dhstp_pkg.sv -----
// ---------------------------------------------------------------------------
// Digest hash set package
// Shared constants, codes, state and result types of the digest hash set.
// ---------------------------------------------------------------------------
package dhstp_pkg;

   localparam int CAPACITY_DEF  = 1024;
   localparam int KEY_WORDS_DEF = 8;
   localparam int WORD_W        = 64;
   localparam int MAX_WORDS     = 8;
   localparam int SHORT_WORDS   = 4;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;
   localparam int OCC_W         = 10;
   localparam int REQ_DATA_W    = MAX_WORDS * WORD_W;
   localparam int REQ_USER_W    = OP_W + 1;
   localparam int RSP_USER_W    = STATUS_W + 1;
   localparam int RSP_DATA_W    = 16;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd3;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PROBE,
      ST_REPLY
   } eng_state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                present;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

endpackage

// ----- rtl/digest_hash_set_triangular_probe_core.sv -----
// ---------------------------------------------------------------------------
// Digest hash set with triangular probing
// Open-addressed set of 256- or 512-bit digest keys held in one slot table.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser: opcode, key_long; tdata: keys
//   rsp      out  rsp_tvalid/tready    tuser: status, present; tdata: occ
//
// Insert and lookup make one read of the slot table for each probe.
// Clear zeroes the whole slot table, one slot written per cycle.
// After reset a clearing pass over every slot runs; req_tready stays low.
// A result register lets the next request start while a result waits.
// ---------------------------------------------------------------------------
module digest_hash_set_triangular_probe_core #(
   parameter int CAPACITY  = dhstp_pkg::CAPACITY_DEF,
   parameter int KEY_WORDS = dhstp_pkg::KEY_WORDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // key_word_0 .. key_word_7, 64 bits each
   input  logic [dhstp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode [1:0], key_long [2]
   input  logic [dhstp_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // occupancy [9:0], zero [15:10]
   output logic [dhstp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status [1:0], present [2]
   output logic [dhstp_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   import dhstp_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int KEY_W = KEY_WORDS * WORD_W;
   localparam int ROW_W = KEY_W + 2;

   logic             eng_res_valid, eng_res_ready;
   rsp_type          eng_res;
   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [ROW_W-1:0] ram_wr_data, ram_rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   dhstp_slot_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ROW_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dhstp_engine #(
      .CAPACITY  (CAPACITY),
      .KEY_WORDS (KEY_WORDS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_op       (req_tuser[OP_W-1:0]),
      .in_key      (req_tdata[KEY_W-1:0]),
      .in_long     (req_tuser[OP_W]),
      .res_valid   (eng_res_valid),
      .res_ready   (eng_res_ready),
      .res         (eng_res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   assign eng_res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (eng_res_valid && eng_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.present, rsp_ff.status};
   assign rsp_tdata  = {(RSP_DATA_W - OCC_W)'(0), rsp_ff.occupancy};

`ifndef SYNTHESIS
   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous still in progress");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (eng_res_valid && eng_res_ready) |=> (rsp_valid_ff && rsp_ff == $past(eng_res)))
      else $error("result register did not take engine result");

   a_present_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.status == STATUS_PRESENT) ? rsp_ff.present :
                        (rsp_ff.status == STATUS_DONE || !rsp_ff.present)))
      else $error("present flag disagrees with status");
`endif

endmodule

// ----- rtl/dhstp_slot_ram.sv -----
// ---------------------------------------------------------------------------
// Slot table memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module dhstp_slot_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 514
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dhstp_engine.sv -----
// ---------------------------------------------------------------------------
// Probe engine
// Triangular probe over the slot table, insert write-back, occupancy count
// and the clearing sweep.
// ---------------------------------------------------------------------------
module dhstp_engine #(
   parameter int CAPACITY  = 1024,
   parameter int KEY_WORDS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [dhstp_pkg::OP_W-1:0]             in_op,
   input  logic [KEY_WORDS*dhstp_pkg::WORD_W-1:0] in_key,
   input  logic                                   in_long,
   output logic                                   res_valid,
   input  logic                                   res_ready,
   output dhstp_pkg::rsp_type                     res,
   output logic                                   ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0]            ram_wr_addr,
   output logic [KEY_WORDS*dhstp_pkg::WORD_W+1:0] ram_wr_data,
   output logic                                   ram_rd_en,
   output logic [$clog2(CAPACITY)-1:0]            ram_rd_addr,
   input  logic [KEY_WORDS*dhstp_pkg::WORD_W+1:0] ram_rd_data
);

   import dhstp_pkg::*;

   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int HALF_CAP = CAPACITY / 2;
   localparam int CNT_W    = $clog2(HALF_CAP + 1);
   localparam int KEY_W    = KEY_WORDS * WORD_W;

   eng_state_type    state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic             long_ff, long_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic             sweep_reply_ff, sweep_reply_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_type          res_ff, res_in;

   logic             row_valid, row_long, is_empty, is_match, probe_end;
   logic [KEY_W-1:0] row_key;
   logic             is_full;

   assign row_key   = ram_rd_data[KEY_W-1:0];
   assign row_valid = ram_rd_data[KEY_W];
   assign row_long  = ram_rd_data[KEY_W+1];
   assign is_empty  = !row_valid;
   assign is_match  = row_valid && (row_long == long_ff) && (row_key == key_ff);
   assign probe_end = is_empty || is_match || (step_ff == '1);
   assign is_full   = (count_ff >= CNT_W'(HALF_CAP)) || !is_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         sweep_ff       <= '0;
         sweep_reply_ff <= 1'b0;
         count_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         sweep_reply_ff <= sweep_reply_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      long_ff <= long_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      long_in        = long_ff;
      key_in         = key_ff;
      idx_in         = idx_ff;
      step_in        = step_ff;
      sweep_in       = sweep_ff;
      sweep_reply_in = sweep_reply_ff;
      count_in       = count_ff;
      res_in         = res_ff;
      in_ready       = 1'b0;
      res_valid      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff;
      ram_wr_data    = {long_ff, 1'b1, key_ff};

      case (state_ff)
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            sweep_in    = sweep_ff + IDX_W'(1);
            if (sweep_ff == '1) begin
               state_in       = sweep_reply_ff ? ST_REPLY : ST_IDLE;
               sweep_reply_in = 1'b0;
            end
         end
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op_in   = in_op;
               long_in = in_long;
               for (int w = 0; w < KEY_WORDS; w++) begin
                  key_in[w*WORD_W +: WORD_W] = (w < SHORT_WORDS || in_long) ?
                                               in_key[w*WORD_W +: WORD_W] : '0;
               end
               case (in_op)
                  OP_INSERT, OP_LOOKUP: begin
                     idx_in      = in_key[IDX_W-1:0];
                     step_in     = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = in_key[IDX_W-1:0];
                     state_in    = ST_PROBE;
                  end
                  OP_CLEAR: begin
                     count_in       = '0;
                     sweep_in       = '0;
                     sweep_reply_in = 1'b1;
                     res_in         = '{status: STATUS_DONE, present: 1'b0, occupancy: '0};
                     state_in       = ST_SWEEP;
                  end
                  default: begin
                     res_in   = '{status: STATUS_DONE, present: 1'b0,
                                  occupancy: OCC_W'(count_ff)};
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (probe_end) begin
               state_in = ST_REPLY;
               if (op_ff == OP_INSERT) begin
                  if (is_match) begin
                     res_in = '{status: STATUS_PRESENT, present: 1'b1,
                                occupancy: OCC_W'(count_ff)};
                  end else if (is_full) begin
                     res_in = '{status: STATUS_FULL, present: 1'b0,
                                occupancy: OCC_W'(count_ff)};
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     res_in    = '{status: STATUS_ADDED, present: 1'b0,
                                   occupancy: OCC_W'(count_ff + CNT_W'(1))};
                  end
               end else begin
                  res_in = '{status: STATUS_DONE, present: is_match,
                             occupancy: OCC_W'(count_ff)};
               end
            end else begin
               idx_in      = idx_ff + step_ff + IDX_W'(1);
               step_in     = step_ff + IDX_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + step_ff + IDX_W'(1);
            end
         end
         ST_REPLY: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule
